FILE: rtl/shlfs_pkg.sv
`default_nettype none

package shlfs_pkg;

   // field widths
   localparam int unsigned HEAT_W = 16;
   localparam int unsigned ERR_W = 16;
   localparam int unsigned TOL_W = 15;
   localparam int unsigned PERIOD_W = 8;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // divider sizing: one quotient bit per step
   localparam int unsigned DIV_STEPS = HEAT_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   // feed status codes
   localparam logic [STATUS_W-1:0] FEED_READY = 2'd0;
   localparam logic [STATUS_W-1:0] FEED_BUSY = 2'd1;
   localparam logic [STATUS_W-1:0] FEED_ERROR = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAT_LIMIT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAT_PER_SHOT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COOLING_AMOUNT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COOLING_PERIOD = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUSY_TIMEOUT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ERROR_HOLD = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE_TOL = 3'd6;

   // register defaults
   localparam logic [HEAT_W-1:0] RST_HEAT_LIMIT = 16'd240;
   localparam logic [HEAT_W-1:0] RST_HEAT_PER_SHOT = 16'd10;
   localparam logic [HEAT_W-1:0] RST_COOLING_AMOUNT = 16'd4;
   localparam logic [PERIOD_W-1:0] RST_COOLING_PERIOD = 8'd10;
   localparam logic [COUNT_W-1:0] RST_BUSY_TIMEOUT = 16'd500;
   localparam logic [COUNT_W-1:0] RST_ERROR_HOLD = 16'd50;
   localparam logic [TOL_W-1:0] RST_SETTLE_TOL = 15'd10;

   typedef struct packed {
      logic fire_request;
      logic heat_tick;
      logic signed [ERR_W-1:0] angle_error;
      logic signed [ERR_W-1:0] speed_error;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] feed_status;
      logic feed_advance;
      logic [HEAT_W-1:0] heat_level;
      logic [HEAT_W-1:0] shots_allowed;
   } rsp_type;

   // divider command and status
   typedef struct packed {
      logic start;
      logic [HEAT_W-1:0] dividend;
      logic [HEAT_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic [HEAT_W-1:0] quotient;
   } div_stat_type;

endpackage

`default_nettype wire

FILE: rtl/shlfs_div.sv
`default_nettype none

module shlfs_div (
   input wire logic clock,
   input wire logic reset,
   input wire shlfs_pkg::div_cmd_type div_cmd,
   output shlfs_pkg::div_stat_type div_stat
);
   import shlfs_pkg::*;

   logic busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic [HEAT_W-1:0] rem_ff, rem_in;
   logic [HEAT_W-1:0] quot_ff, quot_in;
   logic [HEAT_W-1:0] dvs_ff, dvs_in;
   logic [HEAT_W:0] shifted;
   logic [HEAT_W:0] diff;

   // one restoring subtract step per cycle
   always_comb begin
      shifted = {rem_ff, quot_ff[HEAT_W-1]};
      diff = shifted - {1'b0, dvs_ff};
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in = rem_ff;
      quot_in = quot_ff;
      dvs_in = dvs_ff;
      if (div_cmd.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in = '0;
         quot_in = div_cmd.dividend;
         dvs_in = div_cmd.divisor;
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
         if (!diff[HEAT_W]) begin
            rem_in = diff[HEAT_W-1:0];
            quot_in = {quot_ff[HEAT_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[HEAT_W-1:0];
            quot_in = {quot_ff[HEAT_W-2:0], 1'b0};
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   // operand and partial result registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quot_ff <= quot_in;
      dvs_ff <= dvs_in;
   end

   assign div_stat.busy = busy_ff;
   assign div_stat.quotient = quot_ff;

endmodule

`default_nettype wire

FILE: rtl/shot_heat_limited_feeder_sequencer_core.sv
// result: a word accepted while idle starts the divider; its result word is registered
//    (rsp_valid high) once the divider is done, later only if the previous result word
//    has not yet been taken; no new word is accepted until the result word is loaded, as
//    the 16-step divider for the shot allowance holds the sequencer out of idle
// reset: synchronous, active high; clears the sequencer, heat, counters and output
//    valid, and loads every register with its default value
`default_nettype none

module shot_heat_limited_feeder_sequencer_core (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire shlfs_pkg::req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output shlfs_pkg::rsp_type rsp_data,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [shlfs_pkg::CSR_INDEX_W-1:0] csr_index,
   input wire logic [shlfs_pkg::CSR_DATA_W-1:0] csr_data
);
   import shlfs_pkg::*;

   typedef enum logic [0:0] {
      SEQ_IDLE,
      SEQ_DIV
   } seq_state_type;

   seq_state_type seq_ff, seq_in;

   // registers
   logic [HEAT_W-1:0] heat_limit_ff;
   logic [HEAT_W-1:0] heat_per_shot_ff;
   logic [HEAT_W-1:0] cooling_amount_ff;
   logic [PERIOD_W-1:0] cooling_period_ff;
   logic [COUNT_W-1:0] busy_timeout_ff;
   logic [COUNT_W-1:0] error_hold_ff;
   logic [TOL_W-1:0] settle_tol_ff;

   // feeder state
   logic [STATUS_W-1:0] feed_state_ff, feed_state_in;
   logic [COUNT_W-1:0] busy_count_ff, busy_count_in;
   logic [COUNT_W-1:0] error_count_ff, error_count_in;
   logic [HEAT_W-1:0] heat_ff, heat_in;
   logic [PERIOD_W-1:0] cool_count_ff, cool_count_in;
   logic advance_ff, advance_in;
   logic over_ff, over_in;
   logic room_zero_ff, room_zero_in;

   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic req_take;
   logic out_free;
   logic load_out;
   logic [PERIOD_W-1:0] cool_inc;
   logic cool_hit;
   logic [HEAT_W-1:0] heat_cooled;
   logic [ERR_W:0] ang_ext, spd_ext;
   logic [ERR_W:0] ang_mag, spd_mag;
   logic settled;
   logic [HEAT_W:0] heat_sum;
   logic [COUNT_W-1:0] busy_inc, error_inc;
   logic [HEAT_W-1:0] room;
   logic [HEAT_W-1:0] allowed;
   div_cmd_type div_cmd;
   div_stat_type div_stat;

   assign req_take = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load_out = (seq_ff == SEQ_DIV) && !div_stat.busy && out_free;

   // cooling, then the feeder state machine, for the word at the input
   always_comb begin
      cool_inc = cool_count_ff + 1'b1;
      cool_hit = req_data.heat_tick && (cool_inc >= cooling_period_ff);
      cool_count_in = cool_count_ff;
      if (req_data.heat_tick) begin
         cool_count_in = cool_hit ? '0 : cool_inc;
      end
      heat_cooled = heat_ff;
      if (cool_hit) begin
         heat_cooled = (heat_ff > cooling_amount_ff) ? heat_ff - cooling_amount_ff : '0;
      end

      ang_ext = {req_data.angle_error[ERR_W-1], req_data.angle_error};
      spd_ext = {req_data.speed_error[ERR_W-1], req_data.speed_error};
      ang_mag = ang_ext[ERR_W] ? (ERR_W+1)'(-ang_ext) : ang_ext;
      spd_mag = spd_ext[ERR_W] ? (ERR_W+1)'(-spd_ext) : spd_ext;
      settled = (ang_mag < (ERR_W+1)'(settle_tol_ff)) &&
                (spd_mag < (ERR_W+1)'(settle_tol_ff));

      heat_sum = {1'b0, heat_cooled} + {1'b0, heat_per_shot_ff};
      busy_inc = busy_count_ff + 1'b1;
      error_inc = error_count_ff + 1'b1;

      heat_in = heat_cooled;
      advance_in = 1'b0;
      busy_count_in = '0;
      error_count_in = '0;
      feed_state_in = FEED_READY;
      case (feed_state_ff)
         FEED_BUSY: begin
            if (busy_inc >= busy_timeout_ff) begin
               feed_state_in = FEED_ERROR;
            end else begin
               busy_count_in = busy_inc;
               feed_state_in = settled ? FEED_READY : FEED_BUSY;
            end
         end
         FEED_ERROR: begin
            if (error_inc < error_hold_ff) begin
               error_count_in = error_inc;
               feed_state_in = FEED_ERROR;
            end
         end
         default: begin
            if (req_data.fire_request && (heat_sum < {1'b0, heat_limit_ff})) begin
               heat_in = heat_sum[HEAT_W-1:0];
               advance_in = 1'b1;
               feed_state_in = FEED_BUSY;
            end
         end
      endcase

      over_in = heat_in > heat_limit_ff;
      room = heat_limit_ff - heat_in;
      room_zero_in = (room == '0);
   end

   // allowance divider
   assign div_cmd.start = req_take;
   assign div_cmd.dividend = room;
   assign div_cmd.divisor = heat_per_shot_ff;

   shlfs_div u_div (
      .clock(clock),
      .reset(reset),
      .div_cmd(div_cmd),
      .div_stat(div_stat)
   );

   // result word assembly
   always_comb begin
      if (over_ff) begin
         allowed = '0;
      end else if (heat_per_shot_ff == '0) begin
         allowed = room_zero_ff ? '0 : '1;
      end else begin
         allowed = div_stat.quotient;
      end
      rsp_data_in.feed_status = feed_state_ff;
      rsp_data_in.feed_advance = advance_ff;
      rsp_data_in.heat_level = heat_ff;
      rsp_data_in.shots_allowed = allowed;
   end

   // sequencer next state
   always_comb begin
      seq_in = seq_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (seq_ff)
         SEQ_IDLE: begin
            if (req_valid) begin
               seq_in = SEQ_DIV;
            end
         end
         SEQ_DIV: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               seq_in = SEQ_IDLE;
            end
         end
         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase
   end

   // state, registers and output word
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= SEQ_IDLE;
         rsp_valid_ff <= 1'b0;
         feed_state_ff <= FEED_READY;
         busy_count_ff <= '0;
         error_count_ff <= '0;
         heat_ff <= '0;
         cool_count_ff <= '0;
         heat_limit_ff <= RST_HEAT_LIMIT;
         heat_per_shot_ff <= RST_HEAT_PER_SHOT;
         cooling_amount_ff <= RST_COOLING_AMOUNT;
         cooling_period_ff <= RST_COOLING_PERIOD;
         busy_timeout_ff <= RST_BUSY_TIMEOUT;
         error_hold_ff <= RST_ERROR_HOLD;
         settle_tol_ff <= RST_SETTLE_TOL;
      end else begin
         seq_ff <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            feed_state_ff <= feed_state_in;
            busy_count_ff <= busy_count_in;
            error_count_ff <= error_count_in;
            heat_ff <= heat_in;
            cool_count_ff <= cool_count_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HEAT_LIMIT: heat_limit_ff <= csr_data;
               CSR_HEAT_PER_SHOT: heat_per_shot_ff <= csr_data;
               CSR_COOLING_AMOUNT: cooling_amount_ff <= csr_data;
               CSR_COOLING_PERIOD: cooling_period_ff <= csr_data[PERIOD_W-1:0];
               CSR_BUSY_TIMEOUT: busy_timeout_ff <= csr_data;
               CSR_ERROR_HOLD: error_hold_ff <= csr_data;
               CSR_SETTLE_TOL: settle_tol_ff <= csr_data[TOL_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // per-word flags and output payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         advance_ff <= advance_in;
         over_ff <= over_in;
         room_zero_ff <= room_zero_in;
      end
      if (load_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign req_ready = (seq_ff == SEQ_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // an accepted word always starts the divider
   a_take_starts_div: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (div_stat.busy && (seq_ff == SEQ_DIV)))
      else $error("divider not running after input word");

   // a shot always leaves the feeder busy
   a_advance_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.feed_advance) |-> (rsp_data.feed_status == FEED_BUSY))
      else $error("feed advance without busy status");

   // nonzero allowance only below the heat limit
   a_allow_room: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.shots_allowed != '0)) |-> (rsp_data.heat_level < heat_limit_ff))
      else $error("shots allowed at or over heat limit");

endmodule

`default_nettype wire

FILE: test/feeder_heat_checker.sv
`default_nettype none

module feeder_heat_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire shlfs_pkg::req_type req_data,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire shlfs_pkg::rsp_type rsp_data,
   input wire logic csr_valid,
   input wire logic csr_ready,
   input wire logic [shlfs_pkg::CSR_INDEX_W-1:0] csr_index,
   input wire logic [shlfs_pkg::CSR_DATA_W-1:0] csr_data,
   output int fail_count,
   output int pending_words,
   output int checked_words,
   output int shot_count,
   output int timeout_count
);
   import shlfs_pkg::*;

   // shadow registers
   logic [HEAT_W-1:0] lim;
   logic [HEAT_W-1:0] per_shot;
   logic [HEAT_W-1:0] drain_amt;
   logic [PERIOD_W-1:0] drain_period;
   logic [COUNT_W-1:0] busy_limit;
   logic [COUNT_W-1:0] hold_limit;
   logic [TOL_W-1:0] tol;

   // predicted sequencer state
   logic [STATUS_W-1:0] seq_state;
   logic [COUNT_W-1:0] busy_ticks;
   logic [COUNT_W-1:0] hold_ticks;
   logic [HEAT_W-1:0] heat;
   logic [PERIOD_W-1:0] drain_ticks;

   rsp_type expected_words[$];
   int mismatches = 0;
   int checked = 0;
   int shots = 0;
   int timeouts = 0;

   assign fail_count = mismatches;
   assign checked_words = checked;
   assign shot_count = shots;
   assign timeout_count = timeouts;

   initial pending_words = 0;

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
   endtask

   // one control tick: cooling, then the sequencer, then the shot allowance
   task automatic predict_tick(input req_type w, output rsp_type r);
      int ang_mag;
      int spd_mag;
      logic [HEAT_W-1:0] room;
      logic [HEAT_W-1:0] allow;
      logic advance;
      ang_mag = int'($signed(w.angle_error));
      spd_mag = int'($signed(w.speed_error));
      if (ang_mag < 0) ang_mag = -ang_mag;
      if (spd_mag < 0) spd_mag = -spd_mag;
      advance = 1'b0;

      // cooling counter and drain
      if (w.heat_tick) begin
         drain_ticks = drain_ticks + 1'b1;
         if (drain_ticks >= drain_period) begin
            drain_ticks = '0;
            heat = (heat > drain_amt) ? heat - drain_amt : '0;
         end
      end

      // sequencer
      if (seq_state == FEED_BUSY) begin
         busy_ticks = busy_ticks + 1'b1;
         hold_ticks = '0;
         if (busy_ticks >= busy_limit) begin
            busy_ticks = '0;
            seq_state = FEED_ERROR;
            timeouts++;
         end else if (ang_mag < int'(tol) && spd_mag < int'(tol)) begin
            seq_state = FEED_READY;
         end
      end else if (seq_state == FEED_ERROR) begin
         busy_ticks = '0;
         hold_ticks = hold_ticks + 1'b1;
         if (hold_ticks >= hold_limit) begin
            hold_ticks = '0;
            seq_state = FEED_READY;
         end
      end else begin
         seq_state = FEED_READY;
         busy_ticks = '0;
         hold_ticks = '0;
         if (w.fire_request && ({1'b0, heat} + {1'b0, per_shot}) < {1'b0, lim}) begin
            heat = heat + per_shot;
            advance = 1'b1;
            seq_state = FEED_BUSY;
            shots++;
         end
      end

      // remaining shots under the ceiling
      if (heat > lim) begin
         allow = '0;
      end else begin
         room = lim - heat;
         if (per_shot == '0)
            allow = (room != '0) ? '1 : '0;
         else
            allow = room / per_shot;
      end

      r.feed_status = seq_state;
      r.feed_advance = advance;
      r.heat_level = heat;
      r.shots_allowed = allow;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         lim = RST_HEAT_LIMIT;
         per_shot = RST_HEAT_PER_SHOT;
         drain_amt = RST_COOLING_AMOUNT;
         drain_period = RST_COOLING_PERIOD;
         busy_limit = RST_BUSY_TIMEOUT;
         hold_limit = RST_ERROR_HOLD;
         tol = RST_SETTLE_TOL;
         seq_state = FEED_READY;
         busy_ticks = '0;
         hold_ticks = '0;
         heat = '0;
         drain_ticks = '0;
         expected_words.delete();
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HEAT_LIMIT: lim = csr_data;
               CSR_HEAT_PER_SHOT: per_shot = csr_data;
               CSR_COOLING_AMOUNT: drain_amt = csr_data;
               CSR_COOLING_PERIOD: drain_period = csr_data[PERIOD_W-1:0];
               CSR_BUSY_TIMEOUT: busy_limit = csr_data;
               CSR_ERROR_HOLD: hold_limit = csr_data;
               CSR_SETTLE_TOL: tol = csr_data[TOL_W-1:0];
               default: ;
            endcase
         end

         // result words against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result word with none expected, heat %0d allowed %0d",
                           $time, got.heat_level, got.shots_allowed);
            end else begin
               want = expected_words.pop_front();
               check_field("feed_status", 16'(want.feed_status), 16'(got.feed_status));
               check_field("feed_advance", 16'(want.feed_advance), 16'(got.feed_advance));
               check_field("heat_level", want.heat_level, got.heat_level);
               check_field("shots_allowed", want.shots_allowed, got.shots_allowed);
               checked++;
            end
         end

         // accepted request words
         if (req_valid && req_ready) begin
            predict_tick(req_data, want);
            expected_words.push_back(want);
         end
      end
      pending_words <= expected_words.size();
   end

endmodule

`default_nettype wire

FILE: test/shot_heat_limited_feeder_sequencer_core_test.sv
`default_nettype none

module shot_heat_limited_feeder_sequencer_core_test;
   import shlfs_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct {
      logic [15:0] lim, per_shot, drain_amt, period, busy_limit, hold_limit, tol;
   } feeder_setup;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int fail_count;
   int pending_words;
   int checked_words;
   int shot_count;
   int timeout_count;

   logic steady_flow = 1'b0;
   int cur_tol = int'(RST_SETTLE_TOL);
   int setups = 1;
   int end_wait;

   shot_heat_limited_feeder_sequencer_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   feeder_heat_checker checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .fail_count(fail_count),
      .pending_words(pending_words),
      .checked_words(checked_words),
      .shot_count(shot_count),
      .timeout_count(timeout_count)
   );

   always #2 clock = ~clock;

   // watchdog
   initial begin
      #2000000;
      $display("watchdog expired with %0d result words outstanding", pending_words);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (steady_flow)
         rsp_ready <= 1'b1;
      else
         rsp_ready <= ($urandom_range(99) >= 23);
   end

   // leaves valid high on return; the caller sends again or lowers it
   task automatic send_word(input req_type w);
      if (!steady_flow && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(8, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic feed_tick(input int fire, input int cool, input int ang, input int spd);
      req_type w;
      w.fire_request = (fire != 0);
      w.heat_tick = (cool != 0);
      w.angle_error = 16'(ang);
      w.speed_error = 16'(spd);
      send_word(w);
   endtask

   // stop sending until every expected result word is back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_regs(input feeder_setup s, input bit touch_unused);
      write_reg(CSR_HEAT_LIMIT, s.lim);
      write_reg(CSR_HEAT_PER_SHOT, s.per_shot);
      write_reg(CSR_COOLING_AMOUNT, s.drain_amt);
      write_reg(CSR_COOLING_PERIOD, s.period);
      write_reg(CSR_BUSY_TIMEOUT, s.busy_limit);
      write_reg(CSR_ERROR_HOLD, s.hold_limit);
      write_reg(CSR_SETTLE_TOL, s.tol);
      if (touch_unused) write_reg(CSR_UNUSED, 16'hFFFF);
      csr_valid <= 1'b0;
      cur_tol = int'(s.tol[TOL_W-1:0]);
      setups++;
   endtask

   function automatic logic [15:0] pick_reg(input int lo, input int hi);
      int roll;
      roll = $urandom_range(99);
      if (roll < 6) return 16'h0000;
      if (roll < 12) return 16'hFFFF;
      return 16'($urandom_range(hi, lo));
   endfunction

   // mostly near the settle window, sometimes anywhere
   function automatic logic [15:0] pick_error(input int spread);
      int v;
      if ($urandom_range(99) < 70) begin
         v = int'($urandom_range(2 * spread)) - spread;
         return 16'(v);
      end
      return 16'($urandom);
   endfunction

   task automatic random_phase(input int count, input bit steady);
      feeder_setup s;
      req_type w;
      int spread;
      s.lim = pick_reg(20, 400);
      s.per_shot = pick_reg(1, 40);
      s.drain_amt = pick_reg(0, 30);
      s.period = pick_reg(1, 6);
      s.busy_limit = pick_reg(1, 25);
      s.hold_limit = pick_reg(1, 12);
      s.tol = pick_reg(0, 40);
      program_regs(s, 1'b0);
      steady_flow <= steady;
      spread = (cur_tol > 200) ? 200 : cur_tol + 3;
      for (int i = 0; i < count; i++) begin
         w.fire_request = ($urandom_range(99) < 55);
         w.heat_tick = 1'($urandom_range(1));
         w.angle_error = pick_error(spread);
         w.speed_error = pick_error(spread);
         send_word(w);
         if ($urandom_range(99) < 3) wait_for_results();
      end
      wait_for_results();
      steady_flow <= 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // defaults: shot, unsettled at the tolerance edge, settle, extreme errors
      feed_tick(1, 1, -32768, 32767);
      feed_tick(1, 0, 10, 0);
      feed_tick(0, 1, -9, 9);
      feed_tick(1, 0, 0, 0);
      feed_tick(0, 0, 0, -10);
      feed_tick(0, 1, 0, 0);
      wait_for_results();

      // zero divisor, zero period, zero timeout, upper data bits masked off
      program_regs('{16'hFFFF, 16'h0000, 16'h0000, 16'hFF00, 16'h0000, 16'h0001, 16'h8000},
                   1'b1);
      feed_tick(1, 1, 0, 0);
      feed_tick(0, 0, 0, 0);
      feed_tick(1, 1, 0, 0);
      feed_tick(1, 0, 1, 1);
      wait_for_results();

      // zero ceiling with every other register at its top
      program_regs('{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
                   1'b0);
      feed_tick(0, 1, -32767, 32767);
      feed_tick(1, 1, 32766, -32766);
      feed_tick(1, 0, 0, 0);
      wait_for_results();

      // clamp at zero, busy timeout, error hold, fill up to the ceiling
      program_regs('{16'd100, 16'd30, 16'hFFFF, 16'd1, 16'd3, 16'd2, 16'd5}, 1'b0);
      feed_tick(1, 1, 0, 0);
      feed_tick(0, 0, 100, 100);
      feed_tick(0, 0, 100, 100);
      feed_tick(0, 0, 100, 100);
      feed_tick(1, 0, 0, 0);
      feed_tick(1, 0, 0, 0);
      feed_tick(1, 0, 4, -4);
      feed_tick(0, 0, -4, 4);
      feed_tick(1, 0, 0, 0);
      feed_tick(0, 0, 0, 0);
      feed_tick(1, 0, 0, 0);
      feed_tick(0, 1, 0, 0);
      wait_for_results();

      // random settings, one phase without random gaps or back-pressure
      for (int p = 0; p < 7; p++)
         random_phase(100, p == 3);

      // drain and settle
      req_valid <= 1'b0;
      end_wait = 0;
      do begin
         @(posedge clock);
         end_wait++;
      end while (pending_words != 0 && end_wait < 20000);
      repeat (40) @(posedge clock);
      if (pending_words != 0)
         $display("%0d result words never arrived", pending_words);

      $display("checked %0d result words across %0d register settings", checked_words, setups);
      $display("%0d shots fired, %0d busy timeouts into error", shot_count, timeout_count);
      if (fail_count == 0 && pending_words == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
rtl/shlfs_pkg.sv
rtl/shlfs_div.sv
rtl/shot_heat_limited_feeder_sequencer_core.sv
test/feeder_heat_checker.sv
test/shot_heat_limited_feeder_sequencer_core_test.sv
